FILE: design/bfa_pkg.sv
// package with constants, command and status types of the frame allocator
`timescale 1ns / 1ps
package bfa_pkg;

  localparam int unsigned MAX_BLOCKS  = 32768;
  localparam int unsigned BLOCK_BYTES = 4096;
  localparam int unsigned WORD_BITS   = 32;
  localparam int unsigned MAP_WORDS   = MAX_BLOCKS / WORD_BITS;
  localparam int unsigned BLOCK_SHIFT = $clog2(BLOCK_BYTES);
  localparam int unsigned BIT_W       = $clog2(WORD_BITS);
  localparam int unsigned WIDX_W      = $clog2(MAP_WORDS);
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned FRAME_W     = ADDR_W - BLOCK_SHIFT;
  localparam int unsigned CNT_W       = 16;
  localparam int unsigned OP_W        = 2;

  typedef enum logic [OP_W-1:0] {
    OP_RESERVE_ALL    = 2'd0,
    OP_RELEASE_REGION = 2'd1,
    OP_ALLOC          = 2'd2,
    OP_FREE           = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_ZERO,
    PTR_FIRST,
    PTR_FREE,
    PTR_INC
  } ptr_sel_e;

  typedef enum logic [2:0] {
    WR_ONES,
    WR_CLEAR_RANGE,
    WR_SET_BIT0,
    WR_SET_HIT,
    WR_CLEAR_ONE
  } wr_mode_e;

  typedef enum logic [2:0] {
    CNT_HOLD,
    CNT_RESERVE,
    CNT_DOWN_N,
    CNT_DOWN_ONE,
    CNT_INC
  } cnt_mode_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DISPATCH,
    ST_FILL,
    ST_REL_RD,
    ST_REL_WR,
    ST_B0_RD,
    ST_B0_WR,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_FREE_RD,
    ST_FREE_WR,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic      load;
    ptr_sel_e  ptr_sel;
    logic      rd;
    logic      wr;
    wr_mode_e  wr_mode;
    cnt_mode_e cnt_mode;
    logic      hit_set;
    logic      res_load;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic ptr_max;
    logic rel_empty;
    logic rel_last;
    logic alloc_none;
    logic scan_last;
    logic free_oob;
    logic word_full;
    logic out_free;
  } status_t;

endpackage

FILE: design/bfa_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module bfa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/bfa_datapath.sv
// datapath: request registers, word pointer, frame map ram, counts and result register
`timescale 1ns / 1ps
module bfa_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bfa_pkg::cmd_t                cmd_i,
  output bfa_pkg::status_t             status_o,
  input  logic [bfa_pkg::OP_W-1:0]     op_i,
  input  logic [bfa_pkg::ADDR_W-1:0]   base_i,
  input  logic [bfa_pkg::ADDR_W-1:0]   size_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [bfa_pkg::ADDR_W-1:0]   block_address_o,
  output logic                         found_o,
  output logic [bfa_pkg::CNT_W-1:0]    used_blocks_o
);
  import bfa_pkg::*;

  logic [OP_W-1:0]    op_q;
  logic [ADDR_W-1:0]  base_q, size_q;
  logic [WIDX_W-1:0]  ptr_q, ptr_d;
  logic [CNT_W-1:0]   used_q, used_d, managed_q, managed_d;
  logic               hit_q;
  logic [ADDR_W-1:0]  hit_addr_q;
  logic               out_valid_q;
  logic [ADDR_W-1:0]  res_addr_q;
  logic               res_found_q;
  logic [CNT_W-1:0]   res_used_q;

  logic [FRAME_W-1:0] first_f, n_f, free_f;
  logic [FRAME_W:0]   end_raw, end_c, last_f;
  logic [WIDX_W-1:0]  first_w, last_w, free_w, scan_end;
  logic [WIDX_W:0]    words;
  logic [BIT_W-1:0]   lo_bit, hi_bit, zero_idx;
  logic [WORD_BITS-1:0] rdata, wdata, range_mask;
  logic [FRAME_W-1:0] total_raw;
  logic [CNT_W-1:0]   total_c;

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_i;
      base_q <= base_i;
      size_q <= size_i;
    end
  end

  // frame arithmetic
  assign first_f  = base_q[ADDR_W-1:BLOCK_SHIFT];
  assign n_f      = size_q[ADDR_W-1:BLOCK_SHIFT];
  assign free_f   = first_f;
  assign end_raw  = {1'b0, first_f} + {1'b0, n_f};
  assign end_c    = (end_raw > (FRAME_W+1)'(MAX_BLOCKS)) ? (FRAME_W+1)'(MAX_BLOCKS) : end_raw;
  assign last_f   = end_c - (FRAME_W+1)'(1);
  assign first_w  = first_f[BIT_W +: WIDX_W];
  assign last_w   = last_f[BIT_W +: WIDX_W];
  assign free_w   = free_f[BIT_W +: WIDX_W];
  assign words    = managed_q[BIT_W +: WIDX_W+1];
  assign scan_end = WIDX_W'(words - (WIDX_W+1)'(1));
  assign total_raw = size_q[ADDR_W-1:BLOCK_SHIFT];
  assign total_c  = (total_raw > FRAME_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                       : CNT_W'(total_raw);

  // word pointer
  always_comb begin
    ptr_d = ptr_q;
    case (cmd_i.ptr_sel)
      PTR_ZERO:  ptr_d = '0;
      PTR_FIRST: ptr_d = first_w;
      PTR_FREE:  ptr_d = free_w;
      PTR_INC:   ptr_d = ptr_q + WIDX_W'(1);
      default:   ptr_d = ptr_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else begin
      ptr_q <= ptr_d;
    end
  end

  // frame map storage
  bfa_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(MAP_WORDS)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr),
    .waddr_i(ptr_q),
    .wdata_i(wdata),
    .re_i   (cmd_i.rd),
    .raddr_i(ptr_q),
    .rdata_o(rdata)
  );

  // lowest clear bit of the word just read
  always_comb begin
    zero_idx = '0;
    for (int i = WORD_BITS-1; i >= 0; i--) begin
      if (!rdata[i]) begin
        zero_idx = BIT_W'(i);
      end
    end
  end

  // range mask for release
  assign lo_bit = (ptr_q == first_w) ? first_f[BIT_W-1:0] : '0;
  assign hi_bit = (ptr_q == last_w) ? last_f[BIT_W-1:0] : BIT_W'(WORD_BITS-1);
  assign range_mask = ({WORD_BITS{1'b1}} << lo_bit) &
                      ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS-1) - hi_bit));

  // write data select
  always_comb begin
    wdata = rdata;
    case (cmd_i.wr_mode)
      WR_ONES:        wdata = '1;
      WR_CLEAR_RANGE: wdata = rdata & ~range_mask;
      WR_SET_BIT0:    wdata = rdata | WORD_BITS'(1);
      WR_SET_HIT:     wdata = rdata | (WORD_BITS'(1) << zero_idx);
      WR_CLEAR_ONE:   wdata = rdata & ~(WORD_BITS'(1) << free_f[BIT_W-1:0]);
      default:        wdata = rdata;
    endcase
  end

  // frame counts
  always_comb begin
    used_d    = used_q;
    managed_d = managed_q;
    case (cmd_i.cnt_mode)
      CNT_RESERVE: begin
        used_d    = total_c;
        managed_d = total_c;
      end
      CNT_DOWN_N:   used_d = ({{(FRAME_W-CNT_W){1'b0}}, used_q} <= n_f) ? '0
                                                             : used_q - CNT_W'(n_f);
      CNT_DOWN_ONE: used_d = (used_q == '0) ? '0 : used_q - CNT_W'(1);
      CNT_INC:      used_d = (used_q < CNT_W'(MAX_BLOCKS)) ? used_q + CNT_W'(1) : used_q;
      default:      used_d = used_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q    <= CNT_W'(MAX_BLOCKS);
      managed_q <= CNT_W'(MAX_BLOCKS);
    end else begin
      used_q    <= used_d;
      managed_q <= managed_d;
    end
  end

  // alloc hit record
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (cmd_i.load) begin
      hit_q <= 1'b0;
    end else if (cmd_i.hit_set) begin
      hit_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      hit_addr_q <= '0;
    end else if (cmd_i.hit_set) begin
      hit_addr_q <= ADDR_W'({ptr_q, zero_idx}) << BLOCK_SHIFT;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_addr_q  <= hit_addr_q;
      res_found_q <= hit_q;
      res_used_q  <= used_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign block_address_o = res_addr_q;
  assign found_o         = res_found_q;
  assign used_blocks_o   = res_used_q;

  // status to the controller
  assign status_o.op         = op_e'(op_q);
  assign status_o.ptr_max    = (ptr_q == WIDX_W'(MAP_WORDS-1));
  assign status_o.rel_empty  = ({1'b0, first_f} >= end_c);
  assign status_o.rel_last   = (ptr_q == last_w);
  assign status_o.alloc_none = (words == '0);
  assign status_o.scan_last  = (ptr_q == scan_end);
  assign status_o.free_oob   = (free_f >= FRAME_W'(MAX_BLOCKS));
  assign status_o.word_full  = (rdata == '1);
  assign status_o.out_free   = !out_valid_q || out_ready_i;

endmodule

FILE: design/bfa_ctrl.sv
// controller state machine sequencing map sweeps, scans and read-modify-writes
`timescale 1ns / 1ps
module bfa_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  bfa_pkg::status_t status_i,
  output bfa_pkg::cmd_t    cmd_o
);
  import bfa_pkg::*;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d        = state_q;
    in_ready_o     = 1'b0;
    cmd_o.load     = 1'b0;
    cmd_o.ptr_sel  = PTR_HOLD;
    cmd_o.rd       = 1'b0;
    cmd_o.wr       = 1'b0;
    cmd_o.wr_mode  = WR_ONES;
    cmd_o.cnt_mode = CNT_HOLD;
    cmd_o.hit_set  = 1'b0;
    cmd_o.res_load = 1'b0;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.wr      = 1'b1;
        cmd_o.ptr_sel = PTR_INC;
        if (status_i.ptr_max) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (status_i.op)
          OP_RESERVE_ALL: begin
            cmd_o.cnt_mode = CNT_RESERVE;
            cmd_o.ptr_sel  = PTR_ZERO;
            state_d        = ST_FILL;
          end
          OP_RELEASE_REGION: begin
            cmd_o.cnt_mode = CNT_DOWN_N;
            if (status_i.rel_empty) begin
              cmd_o.ptr_sel = PTR_ZERO;
              state_d       = ST_B0_RD;
            end else begin
              cmd_o.ptr_sel = PTR_FIRST;
              state_d       = ST_REL_RD;
            end
          end
          OP_ALLOC: begin
            cmd_o.ptr_sel = PTR_ZERO;
            state_d       = status_i.alloc_none ? ST_FIN : ST_SCAN_RD;
          end
          default: begin
            cmd_o.cnt_mode = CNT_DOWN_ONE;
            cmd_o.ptr_sel  = PTR_FREE;
            state_d        = status_i.free_oob ? ST_FIN : ST_FREE_RD;
          end
        endcase
      end
      ST_FILL: begin
        cmd_o.wr      = 1'b1;
        cmd_o.ptr_sel = PTR_INC;
        if (status_i.ptr_max) begin
          state_d = ST_FIN;
        end
      end
      ST_REL_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_REL_WR;
      end
      ST_REL_WR: begin
        cmd_o.wr      = 1'b1;
        cmd_o.wr_mode = WR_CLEAR_RANGE;
        if (status_i.rel_last) begin
          cmd_o.ptr_sel = PTR_ZERO;
          state_d       = ST_B0_RD;
        end else begin
          cmd_o.ptr_sel = PTR_INC;
          state_d       = ST_REL_RD;
        end
      end
      ST_B0_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_B0_WR;
      end
      ST_B0_WR: begin
        cmd_o.wr      = 1'b1;
        cmd_o.wr_mode = WR_SET_BIT0;
        state_d       = ST_FIN;
      end
      ST_SCAN_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        if (!status_i.word_full) begin
          cmd_o.wr       = 1'b1;
          cmd_o.wr_mode  = WR_SET_HIT;
          cmd_o.hit_set  = 1'b1;
          cmd_o.cnt_mode = CNT_INC;
          state_d        = ST_FIN;
        end else if (status_i.scan_last) begin
          state_d = ST_FIN;
        end else begin
          cmd_o.ptr_sel = PTR_INC;
          state_d       = ST_SCAN_RD;
        end
      end
      ST_FREE_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_FREE_WR;
      end
      ST_FREE_WR: begin
        cmd_o.wr      = 1'b1;
        cmd_o.wr_mode = WR_CLEAR_ONE;
        state_d       = ST_FIN;
      end
      ST_FIN: begin
        if (status_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

FILE: design/bitmap_frame_allocator_unit.sv
// top level of the bitmap page frame allocator
// one request at a time; the map ram holds 1024 words and has one registered read port,
// so a bit update reads the word and then writes it back in a separate state
// reset: asynchronous active low; afterwards an init pass writes all ones into all 1024
// map words while no request is taken; counts reset to the full frame total
`timescale 1ns / 1ps
module bitmap_frame_allocator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // base_address[31:0], region_bytes[63:32]
  input  logic [1:0]  s_axis_tuser_i,   // operation[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // block_address[31:0], used_blocks[47:32]
  output logic        m_axis_tuser_o    // found[0]
);
  import bfa_pkg::*;

  cmd_t              cmd;
  status_t           status;
  logic [ADDR_W-1:0] block_address;
  logic              found;
  logic [CNT_W-1:0]  used_blocks;

  // controller
  bfa_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid_i),
    .in_ready_o(s_axis_tready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  // datapath
  bfa_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .op_i           (s_axis_tuser_i),
    .base_i         (s_axis_tdata_i[31:0]),
    .size_i         (s_axis_tdata_i[63:32]),
    .out_ready_i    (m_axis_tready_i),
    .out_valid_o    (m_axis_tvalid_o),
    .block_address_o(block_address),
    .found_o        (found),
    .used_blocks_o  (used_blocks)
  );

  assign m_axis_tdata_o = {used_blocks, block_address};
  assign m_axis_tuser_o = found;

endmodule
